>>> rtl/rip_pkg.sv
// ----------------------------------------------------------------------------
// Ring interference pixel generator package
// Shared widths, register map, ring rates and the quarter-wave |sin| table.
// ----------------------------------------------------------------------------
package rip_pkg;

  // Screen geometry and field widths
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int PX_W          = 9;
  localparam int PY_W          = 8;
  localparam int ADDR_W        = 17;
  localparam int GRAY_W        = 8;
  localparam int CENTER_W      = 10;
  localparam int NUM_RINGS     = 3;

  // Datapath widths: dx in [-511, 1023], dy in [-511, 767], d2 < 2^21
  localparam int DIFF_W        = 12;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int D2_W          = 21;
  localparam int RATE_W        = 20;
  localparam int PROD_W        = D2_W + RATE_W;
  localparam int RATE_FRAC     = 34;
  localparam int TERM_W        = 8;

  // Pipeline depth: diff, d2, phase, lookup, sum
  localparam int NUM_STAGES    = 5;

  // Phase rates in turns per unit, 34 fraction bits
  localparam logic [RATE_W-1:0] RING_RATE [NUM_RINGS] = '{
    RATE_W'(546852), RATE_W'(546852), RATE_W'(273426)
  };

  // APB register map
  localparam int PDATA_W       = 32;
  localparam int PADDR_W       = 5;
  localparam int REG_IDX_W     = 3;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_X_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y_A = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X_B = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y_B = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X_C = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y_C = 3'd5;

  localparam logic signed [CENTER_W-1:0] CENTER_X_RESET [NUM_RINGS] = '{
    CENTER_W'(100), CENTER_W'(150), CENTER_W'(120)
  };
  localparam logic signed [CENTER_W-1:0] CENTER_Y_RESET [NUM_RINGS] = '{
    CENTER_W'(200), CENTER_W'(250), CENTER_W'(230)
  };

  // Sine table geometry
  localparam int TBL_BITS      = 10;
  localparam int TBL_SIZE      = 1 << TBL_BITS;
  localparam int HALF_SIZE     = TBL_SIZE / 2;
  localparam int QTR_SIZE      = TBL_SIZE / 4;
  localparam int QTR_W         = TBL_BITS - 2;
  localparam int HALF_W        = TBL_BITS - 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int          ONE_Q30     = 30;
  localparam logic [TERM_W-1:0] TERM_PEAK = TERM_W'(128);

  // Taylor divisors (2k)(2k+1) for k = 1..7
  localparam logic [63:0] TAYLOR_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  typedef logic [TERM_W-1:0] qtr_tbl_t [QTR_SIZE];

  // floor(128*sin) over a quarter wave, Q30 Taylor series to x^15
  function automatic logic [TERM_W-1:0] quarter_value(int unsigned h);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        res;
    logic signed [63:0] sum;
    if (h == 0) begin
      return '0;
    end
    if (h >= QTR_SIZE) begin
      return TERM_PEAK;
    end
    x    = (64'(h) * HALF_PI_Q30 + 64'(QTR_SIZE / 2)) / QTR_SIZE;
    x2   = (x * x) >> ONE_Q30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> ONE_Q30;
      term = term / TAYLOR_DIV[k-1];
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    res = ($unsigned(sum) * 64'd128) >> ONE_Q30;
    if (res > 64'(TERM_PEAK)) begin
      res = 64'(TERM_PEAK);
    end
    return res[TERM_W-1:0];
  endfunction

  function automatic qtr_tbl_t build_qtr_tbl();
    qtr_tbl_t t;
    for (int h = 0; h < QTR_SIZE; h++) begin
      t[h] = quarter_value(h);
    end
    return t;
  endfunction

  localparam qtr_tbl_t QTR_TBL = build_qtr_tbl();

endpackage

>>> rtl/rip_ring_lane.sv
// ----------------------------------------------------------------------------
// Ring lane
// One ring's term: difference, squared distance, phase index, |sin| lookup.
// Four register stages, all advancing on en_i.
// ----------------------------------------------------------------------------
module rip_ring_lane (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [rip_pkg::PX_W-1:0]              pixel_x_i,
  input  logic [rip_pkg::PY_W-1:0]              pixel_y_i,
  input  logic signed [rip_pkg::CENTER_W-1:0]   center_x_i,
  input  logic signed [rip_pkg::CENTER_W-1:0]   center_y_i,
  input  logic [rip_pkg::RATE_W-1:0]            rate_i,
  output logic [rip_pkg::TERM_W-1:0]            term_o
);
  import rip_pkg::*;

  logic signed [DIFF_W-1:0] dx_d, dx_q;
  logic signed [DIFF_W-1:0] dy_d, dy_q;
  logic signed [SQ_W-1:0]   sq_x, sq_y;
  logic [D2_W-1:0]          d2_d, d2_q;
  logic [PROD_W-1:0]        prod;
  logic [TBL_BITS-1:0]      idx_d, idx_q;
  logic [HALF_W-1:0]        half_pos;
  logic [HALF_W-1:0]        fold_pos;
  logic [TERM_W-1:0]        term_d, term_q;

  // Stage 1: offsets from the centre
  always_comb begin
    dx_d = $signed({{(DIFF_W-PX_W){1'b0}}, pixel_x_i}) - DIFF_W'(center_x_i);
    dy_d = $signed({{(DIFF_W-PY_W){1'b0}}, pixel_y_i}) - DIFF_W'(center_y_i);
  end

  // Stage 2: squared distance
  always_comb begin
    sq_x = dx_q * dx_q;
    sq_y = dy_q * dy_q;
    d2_d = D2_W'($unsigned(sq_x)) + D2_W'($unsigned(sq_y));
  end

  // Stage 3: phase as a turn fraction
  always_comb begin
    prod  = PROD_W'(d2_q) * PROD_W'(rate_i);
    idx_d = prod[RATE_FRAC-1 -: TBL_BITS];
  end

  // Stage 4: fold onto the quarter wave and look up
  always_comb begin
    half_pos = idx_q[HALF_W-1:0];
    if (half_pos > HALF_W'(QTR_SIZE)) begin
      fold_pos = HALF_W'(HALF_SIZE - int'(half_pos));
    end else begin
      fold_pos = half_pos;
    end
    if (fold_pos == HALF_W'(QTR_SIZE)) begin
      term_d = TERM_PEAK;
    end else begin
      term_d = QTR_TBL[fold_pos[QTR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      d2_q   <= d2_d;
      idx_q  <= idx_d;
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

>>> rtl/ring_interference_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// Ring interference pixel generator
// Gray level from three |sin| ring patterns plus the framebuffer address.
//
//   channel   direction  handshake                 beat
//   pixel     in         in_valid_i / in_ready_o   pixel_x_i, pixel_y_i
//   result    out        out_valid_o / out_ready_i fb_address_o, gray_o
//   config    in         APB psel/penable/pwrite   centre registers
//
// One pixel per cycle while the output is not stalled; each beat passes
// through the five-stage datapath (diff, square, phase multiply, table
// lookup, sum) to the output register.
// A stall on the output freezes every stage together; nothing is dropped.
// Reset clears the stage valid bits and loads the default centres.
// ----------------------------------------------------------------------------
module ring_interference_pixel_generator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rip_pkg::PX_W-1:0]            pixel_x_i,
  input  logic [rip_pkg::PY_W-1:0]            pixel_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rip_pkg::ADDR_W-1:0]          fb_address_o,
  output logic [rip_pkg::GRAY_W-1:0]          gray_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rip_pkg::PADDR_W-1:0]         paddr,
  input  logic [rip_pkg::PDATA_W-1:0]         pwdata,
  output logic [rip_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);
  import rip_pkg::*;

  logic                              pipe_en;
  logic [NUM_STAGES-1:0]             vld_q;
  logic [ADDR_W-1:0]                 addr_d;
  logic [ADDR_W-1:0]                 addr_q [NUM_STAGES];
  logic [TERM_W-1:0]                 term   [NUM_RINGS];
  logic [GRAY_W+1:0]                 sum_full;
  logic [GRAY_W-1:0]                 gray_d, gray_q;

  logic signed [CENTER_W-1:0]        center_x_q [NUM_RINGS];
  logic signed [CENTER_W-1:0]        center_y_q [NUM_RINGS];
  logic                              cfg_wr;
  logic [REG_IDX_W-1:0]              reg_idx;
  logic signed [CENTER_W-1:0]        wr_val;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_val  = $signed(pwdata[CENTER_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_X_RESET;
      center_y_q <= CENTER_Y_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CENTER_X_A: center_x_q[0] <= wr_val;
        REG_CENTER_Y_A: center_y_q[0] <= wr_val;
        REG_CENTER_X_B: center_x_q[1] <= wr_val;
        REG_CENTER_Y_B: center_y_q[1] <= wr_val;
        REG_CENTER_X_C: center_x_q[2] <= wr_val;
        REG_CENTER_Y_C: center_y_q[2] <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X_A: prdata = PDATA_W'(center_x_q[0]);
      REG_CENTER_Y_A: prdata = PDATA_W'(center_y_q[0]);
      REG_CENTER_X_B: prdata = PDATA_W'(center_x_q[1]);
      REG_CENTER_Y_B: prdata = PDATA_W'(center_y_q[1]);
      REG_CENTER_X_C: prdata = PDATA_W'(center_x_q[2]);
      REG_CENTER_Y_C: prdata = PDATA_W'(center_y_q[2]);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: all stages advance unless the output beat is held
  // --------------------------------------------------------------------------
  assign pipe_en     = !vld_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o  = pipe_en;
  assign out_valid_o = vld_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Ring lanes
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_RINGS; g++) begin : g_ring
    rip_ring_lane u_lane (
      .clk_i      (clk_i),
      .en_i       (pipe_en),
      .pixel_x_i  (pixel_x_i),
      .pixel_y_i  (pixel_y_i),
      .center_x_i (center_x_q[g]),
      .center_y_i (center_y_q[g]),
      .rate_i     (RING_RATE[g]),
      .term_o     (term[g])
    );
  end

  // --------------------------------------------------------------------------
  // Address path and final sum
  // --------------------------------------------------------------------------
  assign addr_d = ADDR_W'(pixel_x_i) + ADDR_W'(pixel_y_i) * ADDR_W'(SCREEN_WIDTH);

  always_comb begin
    sum_full = (GRAY_W+2)'(term[0]) + (GRAY_W+2)'(term[1]) + (GRAY_W+2)'(term[2]);
    // wrap to 8 bits
    gray_d   = sum_full[GRAY_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      addr_q[0] <= addr_d;
      for (int s = 1; s < NUM_STAGES; s++) begin
        addr_q[s] <= addr_q[s-1];
      end
      gray_q <= gray_d;
    end
  end

  assign fb_address_o = addr_q[NUM_STAGES-1];
  assign gray_o       = gray_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_holds_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> vld_q == $past(vld_q))
    else $error("stage valid bits changed during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat missing from first stage");

  a_term_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NUM_STAGES-2] |-> term[0] <= TERM_PEAK && term[1] <= TERM_PEAK
                            && term[2] <= TERM_PEAK)
    else $error("ring term above table peak");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && reg_idx == REG_CENTER_X_A |=> center_x_q[0] == $past(wr_val))
    else $error("centre register write lost");

endmodule
